[rtl/lfu_block_cache_directory_top_assert.svh]
// assertion macros for the lfu block cache directory
// expects i_clk and i_rst_n in the module that includes it
`ifndef LFU_BLOCK_CACHE_DIRECTORY_TOP_ASSERT_SVH
`define LFU_BLOCK_CACHE_DIRECTORY_TOP_ASSERT_SVH

// same-cycle implication, off while reset is held
`define LBCD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define LBCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lfu_bcd_pkg.sv]
// shared types and constants of the lfu block cache directory
// no dependencies
package lfu_bcd_pkg;

    localparam int FILE_W = 16;
    localparam int BLK_W  = 32;
    localparam int USE_W  = 32;
    localparam int SLOT_W = 4;
    localparam int RCNT_W = 5;

    localparam logic [USE_W-1:0] USES_MAX = {USE_W{1'b1}};

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_RENAME = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDT
    } t_state;

    // one directory entry as read back from the store
    typedef struct packed {
        logic              vld;
        logic [FILE_W-1:0] file;
        logic [BLK_W-1:0]  block;
        logic [USE_W-1:0]  uses;
    } t_entry;

    // write command into the store
    typedef struct packed {
        logic              we_file;
        logic              we_block;
        logic              we_uses;
        logic              set_vld;
        logic [FILE_W-1:0] file;
        logic [BLK_W-1:0]  block;
        logic [USE_W-1:0]  uses;
    } t_wr_cmd;

    // what the scan has gathered so far
    typedef struct packed {
        logic              found;
        logic [USE_W-1:0]  fuses;
        logic              vvld;
        logic [FILE_W-1:0] vfile;
        logic [BLK_W-1:0]  vblk;
    } t_scan_st;

endpackage

[rtl/lfu_bcd_store.sv]
// entry store: file, block and use memories plus per-entry valid flops
// depends on lfu_bcd_pkg
module lfu_bcd_store
    import lfu_bcd_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_ent,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_wr_cmd          i_wr
);

    logic [FILE_W-1:0] r_file_mem [ENTRIES];
    logic [BLK_W-1:0]  r_blk_mem  [ENTRIES];
    logic [USE_W-1:0]  r_use_mem  [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    t_entry            r_rd_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.set_vld) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_file) begin
            r_file_mem[i_wr_addr] <= i_wr.file;
        end
        if (i_wr.we_block) begin
            r_blk_mem[i_wr_addr] <= i_wr.block;
        end
        if (i_wr.we_uses) begin
            r_use_mem[i_wr_addr] <= i_wr.uses;
        end
    end

    // registered read; an empty entry reads with count zero
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_ent.vld   <= r_vld[i_rd_addr];
            r_rd_ent.file  <= r_file_mem[i_rd_addr];
            r_rd_ent.block <= r_blk_mem[i_rd_addr];
            r_rd_ent.uses  <= r_vld[i_rd_addr] ? r_use_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_ent = r_rd_ent;

endmodule

[rtl/lfu_bcd_scan.sv]
// shared compare unit: one entry per cycle while i_en is high, first match and least count
// depends on lfu_bcd_pkg
module lfu_bcd_scan
    import lfu_bcd_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W = $clog2(ENTRIES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_en,
    input  logic              i_kind,
    input  logic [FILE_W-1:0] i_fid,
    input  logic [BLK_W-1:0]  i_blk,
    input  t_entry            i_ent,
    input  logic [IDX_W-1:0]  i_idx,
    output logic              o_match,
    output t_scan_st          o_st,
    output logic [IDX_W-1:0]  o_fidx,
    output logic [IDX_W-1:0]  o_vidx,
    output logic [CNT_W-1:0]  o_rcnt
);

    logic             r_found;
    logic             r_have;
    logic [CNT_W-1:0] r_rcnt;
    logic [USE_W-1:0] r_fuses;
    logic [USE_W-1:0] r_least;
    logic [IDX_W-1:0] r_fidx;
    logic [IDX_W-1:0] r_vidx;
    logic             r_vvld;
    logic [FILE_W-1:0] r_vfile;
    logic [BLK_W-1:0]  r_vblk;
    logic             less;

    // rename matches on file alone, access on file and block
    assign o_match = i_ent.vld && (i_ent.file == i_fid)
                     && ((i_kind == KIND_RENAME) || (i_ent.block == i_blk));
    // strict less so the lowest index wins a tie
    assign less = !r_have || (i_ent.uses < r_least);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_found <= 1'b0;
            r_have  <= 1'b0;
            r_rcnt  <= '0;
        end else if (i_en) begin
            if (o_match && !r_found) begin
                r_found <= 1'b1;
            end
            if (less) begin
                r_have <= 1'b1;
            end
            if (o_match) begin
                r_rcnt <= r_rcnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (o_match && !r_found) begin
                r_fidx  <= i_idx;
                r_fuses <= i_ent.uses;
            end
            if (less) begin
                r_least <= i_ent.uses;
                r_vidx  <= i_idx;
                r_vvld  <= i_ent.vld;
                r_vfile <= i_ent.file;
                r_vblk  <= i_ent.block;
            end
        end
    end

    assign o_st.found = r_found;
    assign o_st.fuses = r_fuses;
    assign o_st.vvld  = r_vvld;
    assign o_st.vfile = r_vfile;
    assign o_st.vblk  = r_vblk;
    assign o_fidx     = r_fidx;
    assign o_vidx     = r_vidx;
    assign o_rcnt     = r_rcnt;

endmodule

[rtl/lfu_block_cache_directory_top.sv]
// top level of the lfu block cache directory: sequencer, result register
// depends on lfu_bcd_pkg, lfu_bcd_store, lfu_bcd_scan and the assertion header
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------------
//  in      | into      | i_in_valid / o_in_stall      | i_kind i_file_id i_block_number
//          |           |                              | i_new_file_id
//  out     | out of    | o_out_valid / i_out_stall    | o_hit o_slot o_use_count
//          |           |                              | o_evicted_* o_renamed_count
//
// after the item is taken, the scan reads each entry in turn through the single compare
// unit, as the store has one read port; then the last read drains, and the write-back
// waits for a free output register; the sequencer then returns to idle for the next item
// synchronous active-low reset empties every entry at once through valid flops
// a finished result waits in the output register; the next item is taken
// meanwhile and only its write-back waits for the register to free up
`include "lfu_block_cache_directory_top_assert.svh"

module lfu_block_cache_directory_top
    import lfu_bcd_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic [FILE_W-1:0] i_file_id,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic [FILE_W-1:0] i_new_file_id,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic [SLOT_W-1:0] o_slot,
    output logic [USE_W-1:0]  o_use_count,
    output logic              o_evicted_valid,
    output logic [FILE_W-1:0] o_evicted_file_id,
    output logic [BLK_W-1:0]  o_evicted_block,
    output logic [RCNT_W-1:0] o_renamed_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // sequencer state
    t_state r_state, n_state;
    logic   in_acc;
    logic   out_free;

    // held item
    logic              r_kind;
    logic [FILE_W-1:0] r_fid;
    logic [BLK_W-1:0]  r_blk;
    logic [FILE_W-1:0] r_nfid;

    // scan addressing: read index and the index whose data is being compared
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_ev_idx;
    logic             r_ev_vld;
    logic             rd_en;

    // store and compare unit hookup
    t_entry           rd_ent;
    t_wr_cmd          wr;
    logic [IDX_W-1:0] wr_addr;
    logic             cur_match;
    t_scan_st         sst;
    logic [IDX_W-1:0] fidx;
    logic [IDX_W-1:0] vidx;
    logic [CNT_W-1:0] rcnt;
    logic [USE_W-1:0] uses_inc;
    logic             done;

    // result register
    logic              r_out_vld;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [USE_W-1:0]  r_use;
    logic              r_ev;
    logic [FILE_W-1:0] r_ev_file;
    logic [BLK_W-1:0]  r_ev_blk;
    logic [RCNT_W-1:0] r_rcnt;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign done       = (r_state == ST_UPDT) && out_free;

    lfu_bcd_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_ent  (rd_ent),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    lfu_bcd_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (in_acc),
        .i_en    (r_ev_vld),
        .i_kind  (r_kind),
        .i_fid   (r_fid),
        .i_blk   (r_blk),
        .i_ent   (rd_ent),
        .i_idx   (r_ev_idx),
        .o_match (cur_match),
        .o_st    (sst),
        .o_fidx  (fidx),
        .o_vidx  (vidx),
        .o_rcnt  (rcnt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_UPDT;
            end
            ST_UPDT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // saturating bump of the hit entry's count
    assign uses_inc = (sst.fuses == USES_MAX) ? USES_MAX : (sst.fuses + USE_W'(1));

    // state outputs: read issue and store writes
    always_comb begin
        rd_en   = 1'b0;
        wr      = '0;
        wr_addr = r_ev_idx;
        case (r_state)
            ST_SCAN: begin
                rd_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
        // rename rewrites each matching entry as it passes the compare unit
        if (r_ev_vld && (r_kind == KIND_RENAME) && cur_match) begin
            wr.we_file = 1'b1;
            wr.file    = r_nfid;
        end
        if (done && (r_kind == KIND_ACCESS)) begin
            if (sst.found) begin
                wr_addr    = fidx;
                wr.we_uses = 1'b1;
                wr.uses    = uses_inc;
            end else begin
                // fill the least used entry, lowest index on a tie
                wr_addr     = vidx;
                wr.we_file  = 1'b1;
                wr.we_block = 1'b1;
                wr.we_uses  = 1'b1;
                wr.set_vld  = 1'b1;
                wr.file     = r_fid;
                wr.block    = r_blk;
                wr.uses     = USE_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ev_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= rd_en;
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // item hold and scan indices
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind   <= i_kind;
            r_fid    <= i_file_id;
            r_blk    <= i_block_number;
            r_nfid   <= i_new_file_id;
            r_rd_idx <= '0;
        end else if (rd_en) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
        if (rd_en) begin
            r_ev_idx <= r_rd_idx;
        end
    end

    // result payload, loaded only when the register is free
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_hit     <= 1'b0;
            r_slot    <= '0;
            r_use     <= '0;
            r_ev      <= 1'b0;
            r_ev_file <= '0;
            r_ev_blk  <= '0;
            r_rcnt    <= '0;
            if (r_kind == KIND_RENAME) begin
                r_rcnt <= RCNT_W'(rcnt);
            end else if (sst.found) begin
                r_hit  <= 1'b1;
                r_slot <= SLOT_W'(fidx);
                r_use  <= uses_inc;
            end else begin
                r_slot <= SLOT_W'(vidx);
                r_use  <= USE_W'(1);
                // evicted fields only when an occupied entry was replaced
                if (sst.vvld) begin
                    r_ev      <= 1'b1;
                    r_ev_file <= sst.vfile;
                    r_ev_blk  <= sst.vblk;
                end
            end
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_hit             = r_hit;
    assign o_slot            = r_slot;
    assign o_use_count       = r_use;
    assign o_evicted_valid   = r_ev;
    assign o_evicted_file_id = r_ev_file;
    assign o_evicted_block   = r_ev_blk;
    assign o_renamed_count   = r_rcnt;

    `LBCD_ASSERT(a_out_from_updt, $rose(r_out_vld), $past(r_state) == ST_UPDT, "result loaded outside write-back")
    `LBCD_ASSERT_NXT(a_updt_to_idle, done, r_state == ST_IDLE && r_out_vld, "write-back did not finish the item")
    `LBCD_ASSERT(a_evict_is_miss, r_out_vld && r_ev, !r_hit && r_use == USE_W'(1) && r_rcnt == '0, "eviction with hit or bad count")
    `LBCD_ASSERT(a_scan_only_busy, r_ev_vld, r_state == ST_SCAN || r_state == ST_LAST, "compare unit active while idle")

endmodule
